### rtl/core/sccm_pkg.sv
`timescale 1ns / 1ps

package sccm_pkg;

  // item kinds on the input channel
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_LATCH = 2'd2,
    OP_IACK  = 2'd3
  } op_e;

  // bus offsets
  localparam logic [2:0] OFF_CTRL_B = 3'd1;
  localparam logic [2:0] OFF_DATA_B = 3'd3;
  localparam logic [2:0] OFF_CTRL_A = 3'd5;

  // write register numbers
  localparam logic [3:0] WR1 = 4'd1;
  localparam logic [3:0] WR2 = 4'd2;
  localparam logic [3:0] WR3 = 4'd3;
  localparam logic [3:0] WR5 = 4'd5;
  localparam logic [3:0] WR9 = 4'd9;

  // status read values and vector arithmetic
  localparam logic [7:0] RR0_TX_EMPTY = 8'h04;
  localparam logic [7:0] RR_RX_AVAIL  = 8'h01;
  localparam logic [7:0] VEC_HI_MASK  = 8'h8f;
  localparam logic [7:0] VEC_HI_ADD   = 8'h20;
  localparam logic [7:0] VEC_LO_MASK  = 8'hf1;
  localparam logic [7:0] VEC_LO_ADD   = 8'h04;

  // number of bytes in one mouse packet
  localparam logic [1:0] PKT_LEN = 2'd3;

  typedef struct packed {
    op_e                op;
    logic [2:0]         offset;
    logic [7:0]         write_data;
    logic [7:0]         mouse_status;
    logic signed [7:0]  mouse_dx;
    logic signed [7:0]  mouse_dy;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_request;
    logic [7:0] vector_out;
    logic       vector_valid;
  } result_t;

  // latch queue control and status
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] data;
  } q_ctl_t;

  typedef struct packed {
    logic       empty;
    logic [7:0] head;
  } q_stat_t;

endpackage

### rtl/core/sccm_if.sv
`timescale 1ns / 1ps

// input item channel
interface sccm_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [2:0]        offset;
  logic [7:0]        write_data;
  logic [7:0]        mouse_status;
  logic signed [7:0] mouse_dx;
  logic signed [7:0] mouse_dy;

  modport source (
    output valid, op, offset, write_data, mouse_status, mouse_dx, mouse_dy,
    input  ready
  );
  modport sink (
    input  valid, op, offset, write_data, mouse_status, mouse_dx, mouse_dy,
    output ready
  );
endinterface

// result item channel
interface sccm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq_request;
  logic [7:0] vector_out;
  logic       vector_valid;

  modport source (
    output valid, read_data, irq_request, vector_out, vector_valid,
    input  ready
  );
  modport sink (
    input  valid, read_data, irq_request, vector_out, vector_valid,
    output ready
  );
endinterface

### rtl/core/sccm_queue.sv
`timescale 1ns / 1ps

module sccm_queue #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sccm_pkg::q_ctl_t ctl_i,
  output sccm_pkg::q_stat_t stat_o
);
  import sccm_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [7:0]       mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             full;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full = (cnt_q == CNT_W'(QUEUE_DEPTH));

  // pointer and count update, a push into a full queue drops the oldest item
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (ctl_i.push) begin
      tail_d = ptr_inc(tail_q);
      if (full) begin
        head_d = ptr_inc(head_q);
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end else if (ctl_i.pop) begin
      head_d = ptr_inc(head_q);
      cnt_d  = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem_q[tail_q] <= ctl_i.data;
    end
  end

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.head  = mem_q[head_q];

endmodule

### rtl/core/sccm_ctrl.sv
`timescale 1ns / 1ps

module sccm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               fire_i,
  input  sccm_pkg::in_item_t item_i,
  input  sccm_pkg::q_stat_t  q_stat_i,
  output sccm_pkg::q_ctl_t   q_ctl_o,
  output sccm_pkg::result_t  res_o
);
  import sccm_pkg::*;

  logic       compat_q;
  logic [3:0] ptr_b_q, ptr_b_d;
  logic       armed_b_q, armed_b_d;
  logic [3:0] ptr_a_q, ptr_a_d;
  logic       armed_a_q, armed_a_d;
  logic [7:0] vector_q, vector_d;
  logic [7:0] wr1b_q, wr1b_d;
  logic [7:0] wr3b_q, wr3b_d;
  logic [7:0] wr5b_q, wr5b_d;
  logic [7:0] wr9b_q, wr9b_d;
  logic [7:0] pkt_q [3];
  logic [7:0] pkt_d [3];
  logic [1:0] pend_q, pend_d;
  logic [7:0] last_q, last_d;

  logic       rts_edge;
  logic       pub;
  logic [7:0] pub_st, pub_x, pub_y;
  logic       rx_avail;
  logic [7:0] data;
  logic [7:0] st;

  assign data     = item_i.write_data;
  assign st       = item_i.mouse_status;
  assign rx_avail = (pend_q != 2'd0);

  // rising edge of rts in channel b write register 5
  assign rts_edge = (item_i.op == OP_WRITE) && (item_i.offset == OFF_CTRL_B) &&
                    armed_b_q && (ptr_b_q == WR5) && !wr5b_q[1] && data[1];

  // item decode and next state
  always_comb begin
    ptr_b_d   = ptr_b_q;
    armed_b_d = armed_b_q;
    ptr_a_d   = ptr_a_q;
    armed_a_d = armed_a_q;
    vector_d  = vector_q;
    wr1b_d    = wr1b_q;
    wr3b_d    = wr3b_q;
    wr5b_d    = wr5b_q;
    wr9b_d    = wr9b_q;
    pkt_d     = pkt_q;
    pend_d    = pend_q;
    last_d    = last_q;
    q_ctl_o   = '0;
    res_o     = '0;
    pub       = 1'b0;
    pub_st    = st;
    pub_x     = item_i.mouse_dx;
    pub_y     = item_i.mouse_dy;

    // packet publish, or status push into the latch queue, on rts edge
    if (rts_edge) begin
      if (compat_q) begin
        if (wr3b_q[0] && !rx_avail && (st != last_q)) begin
          last_d = st;
          pub    = 1'b1;
        end
      end else if (rx_avail) begin
        q_ctl_o.push = 1'b1;
        q_ctl_o.data = st;
      end else if (!q_stat_i.empty) begin
        q_ctl_o.pop = 1'b1;
        pub         = 1'b1;
        pub_st      = q_stat_i.head;
        pub_x       = '0;
        pub_y       = '0;
      end else begin
        pub = 1'b1;
      end
    end

    if (pub) begin
      pkt_d[2] = pub_st;
      pkt_d[1] = pub_x;
      pkt_d[0] = pub_y;
      pend_d   = PKT_LEN;
      res_o.irq_request = wr9b_q[3] && ((wr1b_q[4:3] == 2'b10) || (wr1b_q[4:3] == 2'b01));
    end

    case (item_i.op)
      OP_WRITE: begin
        if (item_i.offset == OFF_CTRL_B) begin
          if (armed_b_q) begin
            case (ptr_b_q)
              WR1:     wr1b_d   = data;
              WR2:     vector_d = data;
              WR3:     wr3b_d   = data;
              WR5:     wr5b_d   = data;
              WR9:     wr9b_d   = data;
              default: ;
            endcase
            armed_b_d = 1'b0;
            ptr_b_d   = '0;
          end else if (data[7:4] == 4'd0) begin
            armed_b_d = 1'b1;
            ptr_b_d   = data[3:0];
          end else begin
            armed_b_d = 1'b0;
            ptr_b_d   = '0;
          end
        end else if (item_i.offset == OFF_CTRL_A) begin
          if (armed_a_q) begin
            if (ptr_a_q == WR2) begin
              vector_d = data;
            end else if (ptr_a_q == WR9) begin
              wr9b_d = data;
            end
            armed_a_d = 1'b0;
            ptr_a_d   = '0;
          end else begin
            ptr_a_d   = data[3:0];
            armed_a_d = (data[3:0] != 4'd0);
          end
        end
      end
      OP_READ: begin
        if (item_i.offset == OFF_CTRL_B) begin
          if (ptr_b_q == 4'd0) begin
            res_o.read_data = {7'd0, rx_avail};
          end
          ptr_b_d   = '0;
          armed_b_d = 1'b0;
        end else if (item_i.offset == OFF_DATA_B) begin
          if (rx_avail) begin
            pend_d          = pend_q - 2'd1;
            res_o.read_data = pkt_q[pend_q - 2'd1];
          end
        end else if (item_i.offset == OFF_CTRL_A) begin
          if (ptr_a_q == 4'd0) begin
            res_o.read_data = (compat_q || !rx_avail) ? RR0_TX_EMPTY
                                                      : (RR0_TX_EMPTY | RR_RX_AVAIL);
          end else if (ptr_a_q == WR3 && rx_avail) begin
            res_o.read_data = compat_q ? RR0_TX_EMPTY : RR_RX_AVAIL;
          end
          ptr_a_d   = '0;
          armed_a_d = 1'b0;
        end
      end
      OP_LATCH: begin
        if (!compat_q) begin
          q_ctl_o.push = 1'b1;
          q_ctl_o.data = st;
        end
      end
      default: begin
        // interrupt acknowledge
        if (!wr9b_q[1]) begin
          res_o.vector_valid = 1'b1;
          if (wr9b_q[0]) begin
            res_o.vector_out = wr9b_q[4] ? ((vector_q & VEC_HI_MASK) + VEC_HI_ADD)
                                         : ((vector_q & VEC_LO_MASK) + VEC_LO_ADD);
          end else begin
            res_o.vector_out = vector_q;
          end
        end
      end
    endcase

    // nothing moves unless the item is taken
    if (!fire_i) begin
      q_ctl_o.push = 1'b0;
      q_ctl_o.pop  = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      compat_q  <= 1'b0;
      ptr_b_q   <= '0;
      armed_b_q <= 1'b0;
      ptr_a_q   <= '0;
      armed_a_q <= 1'b0;
      vector_q  <= '0;
      wr1b_q    <= '0;
      wr3b_q    <= '0;
      wr5b_q    <= '0;
      wr9b_q    <= '0;
      pkt_q     <= '{default: '0};
      pend_q    <= '0;
      last_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        compat_q <= cfg_wdata_i;
      end
      if (fire_i) begin
        ptr_b_q   <= ptr_b_d;
        armed_b_q <= armed_b_d;
        ptr_a_q   <= ptr_a_d;
        armed_a_q <= armed_a_d;
        vector_q  <= vector_d;
        wr1b_q    <= wr1b_d;
        wr3b_q    <= wr3b_d;
        wr5b_q    <= wr5b_d;
        wr9b_q    <= wr9b_d;
        pkt_q     <= pkt_d;
        pend_q    <= pend_d;
        last_q    <= last_d;
      end
    end
  end

endmodule

### rtl/core/scc_mouse_channel_registers_unit.sv
`timescale 1ns / 1ps

// mouse channel registers of a two-channel serial controller
// in_if carries one bus access or event per item: write, read, latch of the
// mouse status, or interrupt acknowledge. out_if returns exactly one result
// item per input item, in order: read byte, interrupt request, and vector.
// cfg_we_i/cfg_wdata_i load the compat mode bit; write only while idle.
// an item is held in an input register, decoded against the register state
// combinationally, and its result lands in the output register; one item is
// accepted every cycle as long as the receiver keeps up.
// when the receiver stalls, the finished result waits in the output register
// and one more item is still taken into the input register; after that
// in_if.ready drops until out_if.ready returns.
// reset clears the register pointers, the write registers, the pending
// packet and the latch queue pointers; the block is ready right after reset.
// the latch queue holds QUEUE_DEPTH statuses, a full queue drops its oldest.
module scc_mouse_channel_registers_unit #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  sccm_in_if.sink     in_if,
  sccm_out_if.source  out_if
);
  import sccm_pkg::*;

  logic     in_vld_q;
  in_item_t in_item_q;
  logic     out_vld_q;
  result_t  out_res_q;
  logic     advance;
  result_t  res;
  q_ctl_t   q_ctl;
  q_stat_t  q_stat;

  // the held item moves on once the output register is free
  assign advance     = in_vld_q && (!out_vld_q || out_if.ready);
  assign in_if.ready = !in_vld_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      in_item_q.op           <= op_e'(in_if.op);
      in_item_q.offset       <= in_if.offset;
      in_item_q.write_data   <= in_if.write_data;
      in_item_q.mouse_status <= in_if.mouse_status;
      in_item_q.mouse_dx     <= in_if.mouse_dx;
      in_item_q.mouse_dy     <= in_if.mouse_dy;
    end
  end

  sccm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (advance),
    .item_i      (in_item_q),
    .q_stat_i    (q_stat),
    .q_ctl_o     (q_ctl),
    .res_o       (res)
  );

  sccm_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (q_ctl),
    .stat_o (q_stat)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign out_if.valid        = out_vld_q;
  assign out_if.read_data    = out_res_q.read_data;
  assign out_if.irq_request  = out_res_q.irq_request;
  assign out_if.vector_out   = out_res_q.vector_out;
  assign out_if.vector_valid = out_res_q.vector_valid;

  // an empty output register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> in_if.ready)
    else $error("input stalled with empty output register");

  // a decoded item always shows up as a result
  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("decoded item lost");

  // results of different item kinds never mix
  a_result_kinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_if.irq_request || out_if.read_data != 8'd0)
      |-> !out_if.vector_valid && out_if.vector_out == 8'd0)
    else $error("vector given with a read or publish result");

  // a pop is only issued on a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_ctl.pop |-> !q_stat.empty && !q_ctl.push)
    else $error("latch queue popped while empty or pushing");

endmodule
